// ----- rtl/core/cspmv_pkg.sv -----
// ----------------------------------------------------------------------------
// cspmv_pkg
// Shared types and constants of the complex CSR sparse matrix-vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cspmv_pkg;

  localparam int MAX_ROWS     = 256;
  localparam int MAX_NONZEROS = 4096;
  localparam int VALUE_W      = 32;
  localparam int ACC_W        = 64;

  localparam int ROW_W   = 8;                          // result row field
  localparam int SLOT_W  = 13;
  localparam int RCNT_W  = 9;
  localparam int COL_W   = 8;
  localparam int RS_AW   = $clog2(MAX_ROWS + 1);       // row-start table
  localparam int NZ_AW   = $clog2(MAX_NONZEROS);       // nonzero store
  localparam int VEC_AW  = $clog2(MAX_ROWS);           // dense vector
  localparam int NZ_DW   = COL_W + 2 * VALUE_W;
  localparam int VEC_DW  = 2 * VALUE_W;

  typedef enum logic [1:0] {
    MODE_ROW_START = 2'd0,
    MODE_NONZERO   = 2'd1,
    MODE_VECTOR    = 2'd2,
    MODE_COMPUTE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SAT   = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                      mode;
    logic [SLOT_W-1:0]          slot;
    logic [SLOT_W-1:0]          row_start_value;
    logic [COL_W-1:0]           column;
    logic signed [VALUE_W-1:0]  real_part;
    logic signed [VALUE_W-1:0]  imag_part;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]           row;
    logic signed [ACC_W-1:0]    result_real;
    logic signed [ACC_W-1:0]    result_imag;
    status_t                    status;
  } out_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/csr_complex_spmv.sv -----
// Compute word: the row span is fetched from the row-start table, then each nonzero
//   takes two RAM reads and six steps of the shared 32x32 multiplier.
// Out-of-range row: ST_FINISH gives the result. Load words keep input ready.
// Input is not ready while a compute word is in work or its result waits for a
//   free output register; a load can be taken while a result waits.
// Synchronous active-low reset clears control and sets row_count to 256.
// ----------------------------------------------------------------------------
// csr_complex_spmv
// Complex CSR sparse matrix times dense vector, Q8.24 values, Q16.48
// saturating accumulator, one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_complex_spmv
  import cspmv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_word_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_word_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [RCNT_W-1:0] cfg_data
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_RS_LO  = 9'b000000010,
    ST_RS_HI  = 9'b000000100,
    ST_SPAN   = 9'b000001000,
    ST_CHECK  = 9'b000010000,
    ST_NZ_RD  = 9'b000100000,
    ST_VEC_RD = 9'b001000000,
    ST_MAC    = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic logic [ACC_W:0] sat_add(logic signed [ACC_W-1:0] a,
                                             logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
      return {1'b1, (a[ACC_W-1] ? ACC_MIN : ACC_MAX)};
    end
    return {1'b0, s};
  endfunction

  state_t                   state_r, state_nxt;
  logic [RCNT_W-1:0]        row_count_r;
  logic [RS_AW-1:0]         slot_r, slot_nxt;
  logic [SLOT_W-1:0]        j_r, j_nxt;
  logic [SLOT_W-1:0]        end_r, end_nxt;
  logic [2:0]               step_r, step_nxt;
  logic signed [ACC_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  term_r, term_nxt;
  logic signed [ACC_W-1:0]  acc_re_r, acc_re_nxt;
  logic signed [ACC_W-1:0]  acc_im_r, acc_im_nxt;
  logic                     sat_r, sat_nxt;
  logic                     err_r, err_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_r, out_nxt;

  logic                     in_fire;
  logic [RCNT_W-1:0]        limit;
  logic                     row_ok;
  logic                     out_free;
  logic [ACC_W:0]           sat_sum;

  // RAM ports
  logic                     rs_we, rs_re;
  logic [RS_AW-1:0]         rs_raddr;
  logic [SLOT_W-1:0]        rs_rdata;
  logic                     nz_we, nz_re;
  logic [NZ_DW-1:0]         nz_rdata;
  logic                     vec_we, vec_re;
  logic [VEC_DW-1:0]        vec_rdata;

  logic [COL_W-1:0]         nz_col;
  logic signed [VALUE_W-1:0] ar, ai, xr, xi, op_a, op_b;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign limit  = (row_count_r > RCNT_W'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : row_count_r;
  assign row_ok = in_data.slot < SLOT_W'(limit);

  assign rs_we  = in_fire && in_data.mode == MODE_ROW_START && 32'(in_data.slot) <= MAX_ROWS;
  assign nz_we  = in_fire && in_data.mode == MODE_NONZERO && 32'(in_data.slot) < MAX_NONZEROS;
  assign vec_we = in_fire && in_data.mode == MODE_VECTOR && 32'(in_data.slot) < MAX_ROWS;

  assign rs_re    = (state_r == ST_RS_LO) || (state_r == ST_RS_HI);
  assign rs_raddr = (state_r == ST_RS_HI) ? slot_r + RS_AW'(1) : slot_r;
  assign nz_re    = (state_r == ST_NZ_RD);
  assign nz_col   = nz_rdata[NZ_DW-1 -: COL_W];
  assign ar       = nz_rdata[2*VALUE_W-1 -: VALUE_W];
  assign ai       = nz_rdata[VALUE_W-1:0];
  assign vec_re   = (state_r == ST_VEC_RD) && 32'(nz_col) < MAX_ROWS;
  assign xr       = vec_rdata[2*VALUE_W-1 -: VALUE_W];
  assign xi       = vec_rdata[VALUE_W-1:0];

  cspmv_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ROWS + 1)) u_rs_ram (
    .clk     (clk),
    .wr_en   (rs_we),
    .wr_addr (in_data.slot[RS_AW-1:0]),
    .wr_data (in_data.row_start_value),
    .rd_en   (rs_re),
    .rd_addr (rs_raddr),
    .rd_data (rs_rdata)
  );

  cspmv_ram #(.WIDTH(NZ_DW), .DEPTH(MAX_NONZEROS)) u_nz_ram (
    .clk     (clk),
    .wr_en   (nz_we),
    .wr_addr (in_data.slot[NZ_AW-1:0]),
    .wr_data ({in_data.column, in_data.real_part, in_data.imag_part}),
    .rd_en   (nz_re),
    .rd_addr (j_r[NZ_AW-1:0]),
    .rd_data (nz_rdata)
  );

  cspmv_ram #(.WIDTH(VEC_DW), .DEPTH(MAX_ROWS)) u_vec_ram (
    .clk     (clk),
    .wr_en   (vec_we),
    .wr_addr (in_data.slot[VEC_AW-1:0]),
    .wr_data ({in_data.real_part, in_data.imag_part}),
    .rd_en   (vec_re),
    .rd_addr (nz_col[VEC_AW-1:0]),
    .rd_data (vec_rdata)
  );

  // shared multiplier operand select
  always_comb begin
    unique case (step_r)
      3'd0:    begin op_a = ar; op_b = xr; end
      3'd1:    begin op_a = ai; op_b = xi; end
      3'd2:    begin op_a = ar; op_b = xi; end
      3'd3:    begin op_a = ai; op_b = xr; end
      default: begin op_a = ar; op_b = xr; end
    endcase
  end

  assign prod_nxt = op_a * op_b;
  assign sat_sum  = (step_r == 3'd3) ? sat_add(acc_re_r, term_r) : sat_add(acc_im_r, term_r);

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    j_nxt         = j_r;
    end_nxt       = end_r;
    step_nxt      = step_r;
    term_nxt      = term_r;
    acc_re_nxt    = acc_re_r;
    acc_im_nxt    = acc_im_r;
    sat_nxt       = sat_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.mode == MODE_COMPUTE) begin
          slot_nxt   = in_data.slot[RS_AW-1:0];
          acc_re_nxt = '0;
          acc_im_nxt = '0;
          sat_nxt    = 1'b0;
          err_nxt    = !row_ok;
          state_nxt  = row_ok ? ST_RS_LO : ST_FINISH;
        end
      end
      ST_RS_LO: state_nxt = ST_RS_HI;
      ST_RS_HI: begin
        j_nxt     = rs_rdata;
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        // clamp the span to the nonzero store
        end_nxt   = (32'(rs_rdata) > MAX_NONZEROS) ? SLOT_W'(MAX_NONZEROS) : rs_rdata;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: state_nxt = (j_r < end_r) ? ST_NZ_RD : ST_FINISH;
      ST_NZ_RD: state_nxt = ST_VEC_RD;
      ST_VEC_RD: begin
        if (32'(nz_col) < MAX_ROWS) begin
          step_nxt  = 3'd0;
          state_nxt = ST_MAC;
        end else begin
          // drop nonzeros whose column is off the vector
          j_nxt     = j_r + SLOT_W'(1);
          state_nxt = ST_CHECK;
        end
      end
      ST_MAC: begin
        step_nxt = step_r + 3'd1;
        unique case (step_r)
          3'd0: ;
          3'd1: term_nxt = prod_r;
          3'd2: term_nxt = term_r - prod_r;
          3'd3: begin
            acc_re_nxt = sat_sum[ACC_W-1:0];
            sat_nxt    = sat_r | sat_sum[ACC_W];
            term_nxt   = prod_r;
          end
          3'd4: term_nxt = term_r + prod_r;
          3'd5: begin
            acc_im_nxt = sat_sum[ACC_W-1:0];
            sat_nxt    = sat_r | sat_sum[ACC_W];
            j_nxt      = j_r + SLOT_W'(1);
            state_nxt  = ST_CHECK;
          end
          default: state_nxt = ST_CHECK;
        endcase
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.row         = slot_r[ROW_W-1:0];
          out_nxt.result_real = acc_re_r;
          out_nxt.result_imag = acc_im_r;
          priority if (err_r) begin
            out_nxt.status = STATUS_RANGE;
          end else if (sat_r) begin
            out_nxt.status = STATUS_SAT;
          end else begin
            out_nxt.status = STATUS_OK;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      row_count_r <= RCNT_W'(MAX_ROWS);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        row_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    j_r      <= j_nxt;
    end_r    <= end_nxt;
    step_r   <= step_nxt;
    prod_r   <= prod_nxt;
    term_r   <= term_nxt;
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
    sat_r    <= sat_nxt;
    err_r    <= err_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/cspmv_ram.sv -----
// ----------------------------------------------------------------------------
// cspmv_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module cspmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cspmv_checker.sv -----
// ----------------------------------------------------------------------------
// cspmv_checker
// Port-level assertions for csr_complex_spmv, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cspmv_checker
  import cspmv_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire in_word_t          in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire out_word_t         out_data
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_RANGE |->
      out_data.result_real == '0 && out_data.result_imag == '0)
    else $error("out-of-range row gave a nonzero sum");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.mode == MODE_COMPUTE |=> !in_ready)
    else $error("input ready right after a compute word");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.mode != MODE_COMPUTE |=> in_ready)
    else $error("input stalled after a load word");

endmodule

bind csr_complex_spmv cspmv_checker u_cspmv_checker (.*);

`default_nettype wire
